// ===== rtl/ptse_pkg.sv =====
// Package for the pulse train segment expander.
// Types, register indexes, mode codes and line bits shared by all rtl files.
package ptse_pkg;

    localparam int DATA_W        = 32;
    localparam int CNT_W         = 5;
    localparam int CFG_IDX_W     = 8;
    localparam int LINES_W       = 4;
    localparam int MAX_CHARGE_PULSES_DEF = 30;
    localparam int QUEUE_DEPTH_DEF       = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MODE            = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_WIDTH     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INHIBIT_TIME    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INHIBIT_DELAY   = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_TIME     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_DELAY    = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_COUNT    = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_INTERVAL = 8'd7;

    localparam logic [LINES_W-1:0] LN_NONE = 4'b0000;
    localparam logic [LINES_W-1:0] LN_WAVE = 4'b0001;
    localparam logic [LINES_W-1:0] LN_INH  = 4'b0010;
    localparam logic [LINES_W-1:0] LN_TOT  = 4'b0100;
    localparam logic [LINES_W-1:0] LN_CHG  = 4'b1000;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_WAVE  = 3'd1,
        MODE_INH   = 3'd2,
        MODE_DUAL  = 3'd3,
        MODE_CHG   = 3'd4,
        MODE_MULTI = 3'd5
    } t_mode;

    typedef struct packed {
        logic [2:0]        mode;
        logic [DATA_W-1:0] pulse_width;
        logic [DATA_W-1:0] inhibit_time;
        logic [DATA_W-1:0] inhibit_delay;
        logic [DATA_W-1:0] charge_time;
        logic [DATA_W-1:0] charge_delay;
        logic [CNT_W-1:0]  charge_count;
        logic [DATA_W-1:0] charge_interval;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0] gap_us;
        logic              first_of_train;
        logic              last_of_train;
    } t_in;

    typedef struct packed {
        logic [LINES_W-1:0] set_lines;
        logic [LINES_W-1:0] clear_lines;
        logic [DATA_W-1:0]  hold_us;
        logic               last_segment;
    } t_out;

    typedef struct packed {
        t_mode             kind;
        logic              first;
        logic              last;
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] hold_last;
    } t_job;

endpackage

// ===== rtl/ptse_cfg.sv =====
// Configuration register file for the segment expander.
// Depends on ptse_pkg.
module ptse_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ptse_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ptse_pkg::DATA_W-1:0]      i_cfg_data,
    output ptse_pkg::t_cfg                   o_cfg
);

    ptse_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ptse_pkg::REG_MODE:            r_cfg.mode            <= i_cfg_data[2:0];
                ptse_pkg::REG_PULSE_WIDTH:     r_cfg.pulse_width     <= i_cfg_data;
                ptse_pkg::REG_INHIBIT_TIME:    r_cfg.inhibit_time    <= i_cfg_data;
                ptse_pkg::REG_INHIBIT_DELAY:   r_cfg.inhibit_delay   <= i_cfg_data;
                ptse_pkg::REG_CHARGE_TIME:     r_cfg.charge_time     <= i_cfg_data;
                ptse_pkg::REG_CHARGE_DELAY:    r_cfg.charge_delay    <= i_cfg_data;
                ptse_pkg::REG_CHARGE_COUNT:    r_cfg.charge_count    <=
                                                   i_cfg_data[ptse_pkg::CNT_W-1:0];
                ptse_pkg::REG_CHARGE_INTERVAL: r_cfg.charge_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/ptse_front.sv =====
// Front end: accepts gap words, classifies the mode, works out the final hold.
// Depends on ptse_pkg.
module ptse_front #(
    parameter int MAX_CHARGE_PULSES = ptse_pkg::MAX_CHARGE_PULSES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ptse_pkg::t_cfg i_cfg,
    input  logic           i_push,
    output logic           o_full,
    input  ptse_pkg::t_in  i_in,
    output logic           o_job_push,
    input  logic           i_job_full,
    output ptse_pkg::t_job o_job
);

    localparam logic [ptse_pkg::CNT_W-1:0] CNT_MAX = ptse_pkg::CNT_W'(MAX_CHARGE_PULSES);

    logic                          r_v;
    ptse_pkg::t_mode               r_kind;
    logic                          r_first;
    logic                          r_last;
    logic [ptse_pkg::CNT_W-1:0]    r_cnt;
    logic [ptse_pkg::DATA_W-1:0]   r_gap;
    logic [ptse_pkg::DATA_W-1:0]   r_sub;

    ptse_pkg::t_mode               kind;
    logic                          take;
    logic                          keep;
    logic [ptse_pkg::CNT_W-1:0]    cnt_sat;
    logic [ptse_pkg::DATA_W-1:0]   chg_sum;
    logic [ptse_pkg::DATA_W+ptse_pkg::CNT_W-1:0] prod;
    logic [ptse_pkg::DATA_W-1:0]   sub;
    logic [ptse_pkg::DATA_W-1:0]   extra;

    always_comb begin
        unique case (i_cfg.mode)
            ptse_pkg::MODE_WAVE:  kind = ptse_pkg::MODE_WAVE;
            ptse_pkg::MODE_INH:   kind = ptse_pkg::MODE_INH;
            ptse_pkg::MODE_DUAL:  kind = ptse_pkg::MODE_DUAL;
            ptse_pkg::MODE_CHG:   kind = ptse_pkg::MODE_CHG;
            ptse_pkg::MODE_MULTI: kind = ptse_pkg::MODE_MULTI;
            default:              kind = ptse_pkg::MODE_OFF;
        endcase
    end

    assign cnt_sat = (i_cfg.charge_count > CNT_MAX) ? CNT_MAX : i_cfg.charge_count;
    assign chg_sum = i_cfg.charge_time + i_cfg.charge_interval;
    assign prod    = (ptse_pkg::DATA_W+ptse_pkg::CNT_W)'(chg_sum) *
                     (ptse_pkg::DATA_W+ptse_pkg::CNT_W)'(cnt_sat);

    // amount taken off the gap for the closing segment
    always_comb begin
        unique case (kind)
            ptse_pkg::MODE_INH,
            ptse_pkg::MODE_DUAL:  sub = i_cfg.inhibit_time - i_cfg.pulse_width;
            ptse_pkg::MODE_CHG:   sub = i_cfg.charge_time + i_cfg.charge_delay;
            ptse_pkg::MODE_MULTI: sub = prod[ptse_pkg::DATA_W-1:0];
            default:              sub = '0;
        endcase
    end

    assign o_full = r_v && i_job_full;
    assign take   = i_push && !o_full;
    assign keep   = r_v && i_job_full;

    assign extra                = (r_kind == ptse_pkg::MODE_MULTI) ? i_cfg.charge_delay : '0;
    assign o_job_push           = r_v && !i_job_full;
    assign o_job.kind           = r_kind;
    assign o_job.first          = r_first;
    assign o_job.last           = r_last;
    assign o_job.cnt            = r_cnt;
    assign o_job.hold_last      = r_gap - r_sub - extra;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!keep) begin
            r_v <= take && (kind != ptse_pkg::MODE_OFF);
        end
        if (!keep && take) begin
            r_kind  <= kind;
            r_first <= i_in.first_of_train;
            r_last  <= i_in.last_of_train;
            r_cnt   <= cnt_sat;
            r_gap   <= i_in.gap_us;
            r_sub   <= sub;
        end
    end

endmodule

// ===== rtl/ptse_fifo.sv =====
// Short job queue between front and back ends.
// Depends on ptse_pkg.
module ptse_fifo #(
    parameter int DEPTH = ptse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ptse_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ptse_pkg::t_job o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ptse_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/ptse_back.sv =====
// Back end: steps through the segments of each job, one word per cycle while the receiver pops.
// Depends on ptse_pkg.
module ptse_back #(
    parameter int MAX_CHARGE_PULSES = ptse_pkg::MAX_CHARGE_PULSES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ptse_pkg::t_cfg i_cfg,
    input  logic           i_job_empty,
    input  ptse_pkg::t_job i_job,
    output logic           o_job_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output ptse_pkg::t_out o_out
);

    localparam int SEG_W = $clog2(2 * MAX_CHARGE_PULSES + 3);

    logic                        r_cur_v;
    ptse_pkg::t_job              r_cur;
    logic [SEG_W-1:0]            r_idx;
    logic                        r_out_v;
    ptse_pkg::t_out              r_out;

    logic                        emit;
    logic                        load;
    logic [SEG_W-1:0]            c2;
    logic [SEG_W-1:0]            last_idx;
    logic                        seg_last;
    logic [ptse_pkg::LINES_W-1:0] seg_set;
    logic [ptse_pkg::LINES_W-1:0] seg_clr;
    logic [ptse_pkg::DATA_W-1:0] seg_hold;
    logic [ptse_pkg::DATA_W-1:0] post;
    logic                        dual_first;
    logic                        dual_last;

    assign c2         = SEG_W'({r_cur.cnt, 1'b0});
    assign post       = i_cfg.inhibit_time - i_cfg.pulse_width - i_cfg.inhibit_delay;
    assign dual_first = (r_cur.kind == ptse_pkg::MODE_DUAL) && r_cur.first;
    assign dual_last  = (r_cur.kind == ptse_pkg::MODE_DUAL) && r_cur.last;

    always_comb begin
        seg_set  = ptse_pkg::LN_NONE;
        seg_clr  = ptse_pkg::LN_NONE;
        seg_hold = r_cur.hold_last;
        last_idx = SEG_W'(3);
        unique case (r_cur.kind)
            ptse_pkg::MODE_WAVE: begin
                last_idx = SEG_W'(1);
                if (r_idx == '0) begin
                    seg_set  = ptse_pkg::LN_WAVE;
                    seg_hold = i_cfg.pulse_width;
                end else begin
                    seg_clr  = ptse_pkg::LN_WAVE;
                end
            end
            ptse_pkg::MODE_INH, ptse_pkg::MODE_DUAL: begin
                case (r_idx)
                    SEG_W'(0): begin
                        seg_set  = dual_first ? (ptse_pkg::LN_INH | ptse_pkg::LN_TOT)
                                              : ptse_pkg::LN_INH;
                        seg_hold = i_cfg.inhibit_delay;
                    end
                    SEG_W'(1): begin
                        seg_set  = ptse_pkg::LN_WAVE;
                        seg_hold = i_cfg.pulse_width;
                    end
                    SEG_W'(2): begin
                        seg_clr  = ptse_pkg::LN_WAVE;
                        seg_hold = post;
                    end
                    default: begin
                        seg_clr  = dual_last ? (ptse_pkg::LN_INH | ptse_pkg::LN_TOT)
                                             : ptse_pkg::LN_INH;
                    end
                endcase
            end
            ptse_pkg::MODE_CHG: begin
                case (r_idx)
                    SEG_W'(0): begin
                        seg_set  = ptse_pkg::LN_CHG;
                        seg_hold = i_cfg.charge_time;
                    end
                    SEG_W'(1): begin
                        seg_clr  = ptse_pkg::LN_CHG;
                        seg_hold = i_cfg.charge_delay;
                    end
                    SEG_W'(2): begin
                        seg_set  = ptse_pkg::LN_WAVE;
                        seg_hold = i_cfg.pulse_width;
                    end
                    default: begin
                        seg_clr  = ptse_pkg::LN_WAVE;
                    end
                endcase
            end
            ptse_pkg::MODE_MULTI: begin
                last_idx = c2 + SEG_W'(2);
                if (r_idx < c2) begin
                    if (r_idx[0]) begin
                        seg_clr  = ptse_pkg::LN_CHG;
                        seg_hold = i_cfg.charge_interval;
                    end else begin
                        seg_set  = ptse_pkg::LN_CHG;
                        seg_hold = i_cfg.charge_time;
                    end
                end else if (r_idx == c2) begin
                    seg_clr  = ptse_pkg::LN_CHG;
                    seg_hold = i_cfg.charge_delay;
                end else if (r_idx == c2 + SEG_W'(1)) begin
                    seg_set  = ptse_pkg::LN_WAVE;
                    seg_hold = i_cfg.pulse_width;
                end else begin
                    seg_clr  = ptse_pkg::LN_WAVE;
                end
            end
            default: ;
        endcase
    end

    assign seg_last  = (r_idx == last_idx);
    assign emit      = r_cur_v && (!r_out_v || i_pop);
    assign load      = !i_job_empty && (!r_cur_v || (emit && seg_last));
    assign o_job_pop = load;
    assign o_empty   = !r_out_v;
    assign o_out     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (load) begin
                r_cur_v <= 1'b1;
            end else if (emit && seg_last) begin
                r_cur_v <= 1'b0;
            end
            if (emit) begin
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
        if (load) begin
            r_cur <= i_job;
            r_idx <= '0;
        end else if (emit) begin
            r_idx <= r_idx + SEG_W'(1);
        end
        if (emit) begin
            r_out.set_lines    <= seg_set;
            r_out.clear_lines  <= seg_clr;
            r_out.hold_us      <= seg_hold;
            r_out.last_segment <= seg_last;
        end
    end

    a_kind_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_v |-> r_cur.kind != ptse_pkg::MODE_OFF)
        else $error("disabled job reached back end");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_v |-> r_idx <= last_idx)
        else $error("segment index past end of job");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && seg_last && i_job_empty) |=> !r_cur_v)
        else $error("back end busy after final segment with no queued job");

endmodule

// ===== rtl/pulse_train_segment_expander_core.sv =====
// Top level of the pulse train segment expander.
// Depends on ptse_pkg, ptse_cfg, ptse_front, ptse_fifo and ptse_back.
//
//  channel | handshake              | word
//  in      | push / full            | t_in  : gap_us, first_of_train, last_of_train
//  out     | pop / empty            | t_out : set_lines, clear_lines, hold_us, last_segment
//  cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Front stage takes one word a cycle unless full. Path: front register, job queue, back
// end job register, output register. Back end issues one segment a cycle while pop is
// held: 2 segments per word in wave mode, 4 in inhibit, dual inhibit and charge modes,
// 2n+3 in multi charge mode with n charge pulses. Disabled modes drop the word in the
// front stage. Synchronous active-low reset. full: job queue full, front register busy.
module pulse_train_segment_expander_core #(
    parameter int MAX_CHARGE_PULSES = ptse_pkg::MAX_CHARGE_PULSES_DEF,
    parameter int QUEUE_DEPTH       = ptse_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  ptse_pkg::t_in                  i_in,
    output logic                           empty,
    input  logic                           pop,
    output ptse_pkg::t_out                 o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ptse_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ptse_pkg::DATA_W-1:0]    i_cfg_data
);

    ptse_pkg::t_cfg cfg;
    ptse_pkg::t_job job_in;
    ptse_pkg::t_job job_out;
    logic           job_push;
    logic           job_full;
    logic           job_pop;
    logic           job_empty;

    ptse_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ptse_front #(
        .MAX_CHARGE_PULSES (MAX_CHARGE_PULSES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_push     (push),
        .o_full     (full),
        .i_in       (i_in),
        .o_job_push (job_push),
        .i_job_full (job_full),
        .o_job      (job_in)
    );

    ptse_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    ptse_back #(
        .MAX_CHARGE_PULSES (MAX_CHARGE_PULSES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (o_out)
    );

endmodule

// ===== test/ptse_segment_checker.sv =====
`timescale 1ns / 1ps
// Segment checker for the pulse train segment expander: tracks register writes,
// expands each accepted gap word into its expected segments and compares them.
// Depends on ptse_pkg.
module ptse_segment_checker
    import ptse_pkg::*;
#(
    parameter int MAX_CHARGE_PULSES = MAX_CHARGE_PULSES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  t_in                  i_word,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  t_out                 i_seg,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending,
    output int                   o_checked
);

    t_cfg regs;
    t_out expected_segments[$];
    int   mismatches = 0;
    int   checked = 0;
    int   pending_q = 0;

    assign o_mismatches = mismatches;
    assign o_checked    = checked;
    assign o_pending    = pending_q;

    task automatic report(input string msg);
        if (mismatches < 40) begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic void add_segment(input logic [LINES_W-1:0] set_l,
                                        input logic [LINES_W-1:0] clr_l,
                                        input logic [DATA_W-1:0] hold);
        t_out s;
        s.set_lines    = set_l;
        s.clear_lines  = clr_l;
        s.hold_us      = hold;
        s.last_segment = 1'b0;
        expected_segments.push_back(s);
    endfunction

    function automatic void expand_gap(input t_in w);
        logic [DATA_W-1:0]  post;
        logic [DATA_W-1:0]  pre;
        logic [DATA_W-1:0]  cnt;
        logic [LINES_W-1:0] open_l;
        logic [LINES_W-1:0] close_l;
        int                 n0;
        n0 = expected_segments.size();
        case (regs.mode)
            MODE_WAVE: begin
                add_segment(LN_WAVE, LN_NONE, regs.pulse_width);
                add_segment(LN_NONE, LN_WAVE, w.gap_us);
            end
            MODE_INH, MODE_DUAL: begin
                post    = regs.inhibit_time - regs.pulse_width - regs.inhibit_delay;
                open_l  = (regs.mode == MODE_DUAL && w.first_of_train) ? (LN_INH | LN_TOT)
                                                                       : LN_INH;
                close_l = (regs.mode == MODE_DUAL && w.last_of_train) ? (LN_INH | LN_TOT)
                                                                      : LN_INH;
                add_segment(open_l, LN_NONE, regs.inhibit_delay);
                add_segment(LN_WAVE, LN_NONE, regs.pulse_width);
                add_segment(LN_NONE, LN_WAVE, post);
                add_segment(LN_NONE, close_l, w.gap_us - post - regs.inhibit_delay);
            end
            MODE_CHG: begin
                pre = regs.charge_time + regs.charge_delay;
                add_segment(LN_CHG, LN_NONE, regs.charge_time);
                add_segment(LN_NONE, LN_CHG, regs.charge_delay);
                add_segment(LN_WAVE, LN_NONE, regs.pulse_width);
                add_segment(LN_NONE, LN_WAVE, w.gap_us - pre);
            end
            MODE_MULTI: begin
                // counts above the limit saturate
                cnt = (regs.charge_count > MAX_CHARGE_PULSES) ? MAX_CHARGE_PULSES
                                                              : regs.charge_count;
                pre = (regs.charge_time + regs.charge_interval) * cnt + regs.charge_delay;
                for (int j = 0; j < cnt; j++) begin
                    add_segment(LN_CHG, LN_NONE, regs.charge_time);
                    add_segment(LN_NONE, LN_CHG, regs.charge_interval);
                end
                add_segment(LN_NONE, LN_CHG, regs.charge_delay);
                add_segment(LN_WAVE, LN_NONE, regs.pulse_width);
                add_segment(LN_NONE, LN_WAVE, w.gap_us - pre);
            end
            default: ;
        endcase
        if (expected_segments.size() > n0) begin
            expected_segments[expected_segments.size() - 1].last_segment = 1'b1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            regs = '0;
            expected_segments.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (expected_segments.size() == 0) begin
                    report($sformatf("segment word with nothing expected (hold %0h)",
                                     i_seg.hold_us));
                end else begin
                    want = expected_segments.pop_front();
                    if (i_seg.set_lines !== want.set_lines)
                        report($sformatf("segment %0d set_lines %0h, want %0h",
                                         checked, i_seg.set_lines, want.set_lines));
                    if (i_seg.clear_lines !== want.clear_lines)
                        report($sformatf("segment %0d clear_lines %0h, want %0h",
                                         checked, i_seg.clear_lines, want.clear_lines));
                    if (i_seg.hold_us !== want.hold_us)
                        report($sformatf("segment %0d hold_us %0h, want %0h",
                                         checked, i_seg.hold_us, want.hold_us));
                    if (i_seg.last_segment !== want.last_segment)
                        report($sformatf("segment %0d last_segment %0b, want %0b",
                                         checked, i_seg.last_segment, want.last_segment));
                end
                checked++;
            end
            if (i_push && !i_full) begin
                expand_gap(i_word);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE:            regs.mode            = i_cfg_data[2:0];
                    REG_PULSE_WIDTH:     regs.pulse_width     = i_cfg_data;
                    REG_INHIBIT_TIME:    regs.inhibit_time    = i_cfg_data;
                    REG_INHIBIT_DELAY:   regs.inhibit_delay   = i_cfg_data;
                    REG_CHARGE_TIME:     regs.charge_time     = i_cfg_data;
                    REG_CHARGE_DELAY:    regs.charge_delay    = i_cfg_data;
                    REG_CHARGE_COUNT:    regs.charge_count    = i_cfg_data[CNT_W-1:0];
                    REG_CHARGE_INTERVAL: regs.charge_interval = i_cfg_data;
                    default: ;
                endcase
            end
        end
        pending_q <= expected_segments.size();
    end

endmodule

// ===== test/pulse_train_segment_expander_core_test.sv =====
`timescale 1ns / 1ps
// Testbench top for pulse_train_segment_expander_core: programs the registers,
// sends gap words in directed and random trains, and gives the verdict.
// Depends on ptse_pkg, the core and ptse_segment_checker.
module pulse_train_segment_expander_core_test;
    import ptse_pkg::*;

    localparam logic [2:0]           MODE_RSVD_6 = 3'd6;
    localparam logic [2:0]           MODE_RSVD_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 8'd200;
    localparam int WORD_TARGET = 240;
    localparam int DRAIN_PAD   = 12;
    localparam int LIMIT_NS    = 30_000_000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    t_in                  word_in = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    t_out                 seg_out;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    logic idle_en = 1'b0;
    int   pop_stall = 0;
    int   mismatches;
    int   pending;
    int   checked;
    int   words_sent = 0;
    int   settings = 0;

    pulse_train_segment_expander_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (word_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (seg_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ptse_segment_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_word       (word_in),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_seg        (seg_out),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #5 i_clk = ~i_clk;

    // receiver: stalls at random while idling is on
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop       <= 1'b0;
            pop_stall <= 0;
        end else if (pop_stall != 0) begin
            pop       <= 1'b0;
            pop_stall <= pop_stall - 1;
        end else if (idle_en && $urandom_range(0, 11) == 0) begin
            pop       <= 1'b0;
            pop_stall <= $urandom_range(0, 13);
        end else begin
            pop <= 1'b1;
        end
    end

    function automatic logic [DATA_W-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'd1;
            3, 4, 5: return $urandom_range(0, 1000);
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [2:0] m, input logic [DATA_W-1:0] pw,
                                input logic [DATA_W-1:0] it, input logic [DATA_W-1:0] id,
                                input logic [DATA_W-1:0] ct, input logic [DATA_W-1:0] cd,
                                input logic [CNT_W-1:0] cc, input logic [DATA_W-1:0] ci,
                                input bit stray);
        logic [DATA_W-1:0] junk;
        junk = $urandom();
        // upper data bits of the narrow registers carry noise
        write_reg(REG_MODE, {junk[31:3], m});
        write_reg(REG_PULSE_WIDTH, pw);
        write_reg(REG_INHIBIT_TIME, it);
        write_reg(REG_INHIBIT_DELAY, id);
        write_reg(REG_CHARGE_TIME, ct);
        write_reg(REG_CHARGE_DELAY, cd);
        write_reg(REG_CHARGE_COUNT, {junk[31:5], cc});
        write_reg(REG_CHARGE_INTERVAL, ci);
        if (stray) begin
            write_reg(REG_UNUSED, '1);
        end else if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(REG_CHARGE_INTERVAL + 1, 255)), $urandom());
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic send_word(input logic [DATA_W-1:0] gap, input logic f, input logic l);
        t_in w;
        w.gap_us         = gap;
        w.first_of_train = f;
        w.last_of_train  = l;
        if (idle_en && $urandom_range(0, 6) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        push    <= 1'b1;
        word_in <= w;
        do @(posedge i_clk); while (full);
        words_sent++;
    endtask

    // hold the sender until every expected segment word is out
    task automatic settle();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    initial begin
        logic [2:0]        m;
        logic [CNT_W-1:0]  cc;
        int                productive;
        int                n;
        int                sent;
        int                len;
        int                hold_at;
        bit                sane;
        bit                pressure_done;
        logic              f;
        logic              l;
        productive    = 0;
        pressure_done = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // directed: registers at reset value, disabled
        send_word('0, 1'b1, 1'b1);
        send_word('1, 1'b0, 1'b0);
        settle();

        program_regs(MODE_WAVE, '1, '0, '0, '0, '0, '0, '0, 1'b0);
        send_word('0, 1'b0, 1'b0);
        send_word('1, 1'b1, 1'b1);
        settle();

        // dual inhibit with wrapping post time, all flag pairs
        program_regs(MODE_DUAL, 32'd5, 32'd3, '1, '0, '0, '0, '0, 1'b0);
        send_word(32'd0, 1'b0, 1'b0);
        send_word('1, 1'b1, 1'b0);
        send_word(32'd7, 1'b0, 1'b1);
        send_word($urandom(), 1'b1, 1'b1);
        settle();

        program_regs(MODE_INH, 32'd10, 32'd100, 32'd20, '1, '1, '1, '1, 1'b0);
        send_word(32'd1000, 1'b1, 1'b1);
        send_word(32'd5, 1'b0, 1'b0);
        settle();

        program_regs(MODE_CHG, '0, '1, '1, '1, '1, '1, '1, 1'b0);
        send_word('0, 1'b1, 1'b0);
        send_word('1, 1'b0, 1'b1);
        settle();

        // multi charge: saturating count, no charge pulses, full count, one pulse
        program_regs(MODE_MULTI, 32'd3, '0, '0, 32'd2, 32'd9, 5'd31, 32'd4, 1'b1);
        send_word(32'd500, 1'b0, 1'b0);
        settle();
        program_regs(MODE_MULTI, '1, '0, '0, '1, '1, 5'd0, '1, 1'b0);
        send_word(32'd0, 1'b1, 1'b1);
        settle();
        program_regs(MODE_MULTI, 32'd1, '0, '0, '1, '0, 5'd30, '1, 1'b0);
        send_word('1, 1'b0, 1'b0);
        settle();
        program_regs(MODE_MULTI, $urandom(), '0, '0, $urandom(), $urandom(), 5'd1,
                     $urandom(), 1'b0);
        send_word($urandom(), 1'b1, 1'b0);
        settle();

        program_regs(MODE_RSVD_6, '1, '1, '1, '1, '1, '1, '1, 1'b0);
        send_word($urandom(), 1'b1, 1'b1);
        settle();
        program_regs(MODE_RSVD_7, '1, '1, '1, '1, '1, '1, '1, 1'b0);
        send_word($urandom(), 1'b0, 1'b1);
        settle();

        // random phases: mostly well-formed trains, some with noisy flags
        while (productive < WORD_TARGET) begin
            m = 3'($urandom_range(MODE_WAVE, MODE_MULTI));
            if ($urandom_range(0, 9) == 0) m = 3'($urandom_range(0, 7));
            cc = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(25, 31))
                                             : CNT_W'($urandom_range(0, 4));
            idle_en <= (productive < WORD_TARGET - 50) && ($urandom_range(0, 3) != 0);
            settle();
            program_regs(m, pick_time(), pick_time(), pick_time(), pick_time(), pick_time(),
                         cc, pick_time(), 1'b0);
            n = $urandom_range(8, 28);
            hold_at = -1;
            if ((m >= MODE_WAVE && m <= MODE_MULTI && !pressure_done)
                || $urandom_range(0, 2) == 0) begin
                hold_at       = $urandom_range(2, n - 2);
                pressure_done = 1;
            end
            sent = 0;
            while (sent < n) begin
                len  = $urandom_range(1, 6);
                if (len > n - sent) len = n - sent;
                sane = ($urandom_range(0, 4) != 0);
                for (int k = 0; k < len; k++) begin
                    if (sent == hold_at) settle();
                    f = sane ? (k == 0) : 1'($urandom_range(0, 1));
                    l = sane ? (k == len - 1) : 1'($urandom_range(0, 1));
                    send_word(pick_time(), f, l);
                    sent++;
                end
            end
            if (m >= MODE_WAVE && m <= MODE_MULTI) productive += n;
        end
        settle();

        $display("covered %0d gap words under %0d register settings, all modes and flag pairs",
                 words_sent, settings);
        $display("%0d segment words compared, %0d mismatches", checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout with %0d segment words outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ptse_pkg.sv
rtl/ptse_cfg.sv
rtl/ptse_front.sv
rtl/ptse_fifo.sv
rtl/ptse_back.sv
rtl/pulse_train_segment_expander_core.sv
test/ptse_segment_checker.sv
test/pulse_train_segment_expander_core_test.sv
